### hw/rtl/cdp_pkg.sv
// Shared types, register codes and constants of the chroma distance pixel block.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package cdp_pkg;

    // Channel, sum and config widths
    localparam int CH_W          = 8;
    localparam int SUM_W         = 10;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 10;

    // Default number of fraction bits
    localparam int FRAC_BITS_DEF = 16;

    // Reciprocal divider: quotient bits resolved per pipeline stage
    localparam int DIV_STEP      = 4;

    // Back end register stages, output register included
    localparam int BACK_LAT      = 5;

    // Distance scale and the divide-by-255 reciprocal (exact below 2^16)
    localparam int SCALE         = 1000;
    localparam int SCALE_W       = 10;
    localparam int RECIP255      = 32897;
    localparam int RECIP_SHIFT   = 23;
    localparam int SAT_LIMIT     = 65280;   // 256 * 255: quotient would pass 255
    localparam int SAT_W         = 16;
    localparam logic [CH_W-1:0] DIST_MAX = 8'hFF;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REF_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_THIRD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_THR   = 3'd4;

    // Register reset values
    localparam logic [CH_W-1:0]  RST_REF_FIRST  = 8'd255;
    localparam logic [CH_W-1:0]  RST_REF_SECOND = 8'd0;
    localparam logic [CH_W-1:0]  RST_REF_THIRD  = 8'd0;
    localparam logic [SUM_W-1:0] RST_DARK_LIMIT = 10'd0;
    localparam logic [CH_W-1:0]  RST_MASK_THR   = 8'd128;

    // Control that travels with a pixel beat
    typedef struct packed {
        logic valid;
        logic dark;
    } cdp_ctl_t;

    // Number of divider stages for a given fraction width
    function automatic int div_stages(input int frac);
        return (2 * frac + 1 + DIV_STEP - 1) / DIV_STEP;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/cdp_recip_div.sv
// Pipelined restoring divider: floor(2^(2F) / divisor), DIV_STEP quotient bits a stage.
// Depends on cdp_pkg; carries a sideband word alongside the divisor.
`default_nettype none

module cdp_recip_div #(
    parameter int FRAC_BITS = cdp_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
) (
    input  wire logic                           clk,
    input  wire logic [cdp_pkg::SUM_W-1:0]      divisor,
    input  wire logic [SIDE_W-1:0]              side_in,
    output logic      [2*FRAC_BITS:0]           recip,
    output logic      [SIDE_W-1:0]              side_out
);

    localparam int QW      = 2 * FRAC_BITS + 1;
    localparam int STEP    = cdp_pkg::DIV_STEP;
    localparam int NSTG    = cdp_pkg::div_stages(FRAC_BITS);
    localparam int W       = NSTG * STEP;
    localparam int TOP_POS = 2 * FRAC_BITS;
    localparam int SW      = cdp_pkg::SUM_W;

    logic [SW-1:0]     rem_reg  [NSTG];
    logic [W-1:0]      quo_reg  [NSTG];
    logic [SW-1:0]     dvs_reg  [NSTG];
    logic [SIDE_W-1:0] side_reg [NSTG];

    genvar g;
    for (g = 0; g < NSTG; g++)
    begin : g_stage
        logic [SW-1:0]     rem_in;
        logic [SW-1:0]     rem_next;
        logic [SW-1:0]     dvs_in;
        logic [W-1:0]      quo_in;
        logic [W-1:0]      quo_next;
        logic [SIDE_W-1:0] side_w;

        // Stage inputs: ports for the first stage, previous stage otherwise
        if (g == 0)
        begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
            assign dvs_in = divisor;
            assign side_w = side_in;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign quo_in = quo_reg[g-1];
            assign dvs_in = dvs_reg[g-1];
            assign side_w = side_reg[g-1];
        end

        // Dividend is a single one at bit 2F, padded with leading zeros
        always_comb
        begin
            logic [SW:0] trial;
            rem_next = rem_in;
            quo_next = quo_in;
            for (int j = 0; j < STEP; j++)
            begin
                trial = {rem_next, 1'((W - 1 - (g * STEP + j)) == TOP_POS)};
                if (trial >= {1'b0, dvs_in})
                begin
                    trial    = trial - {1'b0, dvs_in};
                    quo_next = {quo_next[W-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_next[W-2:0], 1'b0};
                end
                rem_next = trial[SW-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g]  <= rem_next;
            quo_reg[g]  <= quo_next;
            dvs_reg[g]  <= dvs_in;
            side_reg[g] <= side_w;
        end
    end

    assign recip    = quo_reg[NSTG-1][QW-1:0];
    assign side_out = side_reg[NSTG-1];

endmodule

`default_nettype wire

### hw/rtl/cdp_chroma_lane.sv
// Chromaticity of one colour: channel sum, reciprocal, two products, rounding.
// Depends on cdp_pkg and cdp_recip_div; divider, product and output registers.
`default_nettype none

module cdp_chroma_lane #(
    parameter int FRAC_BITS = cdp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic [cdp_pkg::CH_W-1:0]      a,
    input  wire logic [cdp_pkg::CH_W-1:0]      b,
    input  wire logic [cdp_pkg::CH_W-1:0]      c,
    output logic signed [FRAC_BITS+1:0]        part0,
    output logic signed [FRAC_BITS+1:0]        part1,
    output logic signed [FRAC_BITS+1:0]        part2
);

    localparam int CW      = cdp_pkg::CH_W;
    localparam int SW      = cdp_pkg::SUM_W;
    localparam int QW      = 2 * FRAC_BITS + 1;
    localparam int MW      = QW + CW;
    localparam int PW      = FRAC_BITS + 2;
    localparam int SIDE_W  = 2 * CW + 1;
    localparam int THIRD_I = (2 * (1 << FRAC_BITS) + 3) / 6;

    localparam logic [MW-1:0]        HALF  = MW'(1) << (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] ONE   = PW'(1) << FRAC_BITS;
    localparam logic signed [PW-1:0] THIRD = PW'(THIRD_I);

    logic [SW-1:0]     sum_w;
    logic [SIDE_W-1:0] side_w;
    logic [QW-1:0]     recip;
    logic [SIDE_W-1:0] side_d;

    // Channel sum and the sideband carried through the divider
    assign sum_w  = SW'(a) + SW'(b) + SW'(c);
    assign side_w = {a, b, (sum_w == '0)};

    cdp_recip_div #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_W)
    ) u_div (
        .clk      (clk),
        .divisor  (sum_w),
        .side_in  (side_w),
        .recip    (recip),
        .side_out (side_d)
    );

    // Products of the two leading components with the reciprocal
    logic [MW-1:0] prod_a_reg, prod_a_next;
    logic [MW-1:0] prod_b_reg, prod_b_next;
    logic          zero_reg;

    assign prod_a_next = MW'(side_d[SIDE_W-1 -: CW]) * MW'(recip);
    assign prod_b_next = MW'(side_d[CW:1]) * MW'(recip);

    always_ff @(posedge clk)
    begin
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        zero_reg   <= side_d[0];
    end

    // Round to F fraction bits, third part closes the sum to one
    logic [MW-1:0]        rnd_a, rnd_b;
    logic [PW-1:0]        pa, pb;
    logic signed [PW-1:0] p0_next, p1_next, p2_next;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg;

    always_comb
    begin
        rnd_a = prod_a_reg + HALF;
        rnd_b = prod_b_reg + HALF;
        pa    = {1'b0, rnd_a[FRAC_BITS +: FRAC_BITS+1]};
        pb    = {1'b0, rnd_b[FRAC_BITS +: FRAC_BITS+1]};
        if (zero_reg)
        begin
            p0_next = THIRD;
            p1_next = THIRD;
            p2_next = THIRD;
        end
        else
        begin
            p0_next = $signed(pa);
            p1_next = $signed(pb);
            p2_next = ONE - $signed(pa) - $signed(pb);
        end
    end

    always_ff @(posedge clk)
    begin
        p0_reg <= p0_next;
        p1_reg <= p1_next;
        p2_reg <= p2_next;
    end

    assign part0 = p0_reg;
    assign part1 = p1_reg;
    assign part2 = p2_reg;

endmodule

`default_nettype wire

### hw/rtl/cdp_dist_back.sv
// Distance back end: squared differences, brightness weight, scale, round, saturate, mask.
// Depends on cdp_pkg; five register stages, the last one is the result register.
`default_nettype none

module cdp_dist_back #(
    parameter int FRAC_BITS = cdp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cdp_pkg::cdp_ctl_t             in_ctl,
    input  wire logic [cdp_pkg::SUM_W-1:0]     sum,
    input  wire logic signed [FRAC_BITS+1:0]   p0,
    input  wire logic signed [FRAC_BITS+1:0]   p1,
    input  wire logic signed [FRAC_BITS+1:0]   p2,
    input  wire logic signed [FRAC_BITS+1:0]   c0,
    input  wire logic signed [FRAC_BITS+1:0]   c1,
    input  wire logic signed [FRAC_BITS+1:0]   c2,
    input  wire logic [cdp_pkg::CH_W-1:0]      mask_threshold,
    output logic                               done,
    output logic [cdp_pkg::CH_W-1:0]           distance,
    output logic                               mask,
    output logic                               dark
);

    localparam int SW  = cdp_pkg::SUM_W;
    localparam int PW  = FRAC_BITS + 2;
    localparam int DW  = FRAC_BITS + 3;
    localparam int SQW = 2 * FRAC_BITS + 1;
    localparam int SSW = 2 * FRAC_BITS + 3;
    localparam int QW  = FRAC_BITS + 3;
    localparam int QSW = QW + SW;
    localparam int NW  = QSW + cdp_pkg::SCALE_W;
    localparam int TW  = NW + 1 - FRAC_BITS;

    localparam logic [SSW-1:0] HALF_Q   = SSW'(1) << (FRAC_BITS - 1);
    localparam logic [NW:0]    DEN_HALF = (NW+1)'(255) << (FRAC_BITS - 1);

    logic signed [PW-1:0] pp [3];
    logic signed [PW-1:0] cc [3];

    assign pp[0] = p0;
    assign pp[1] = p1;
    assign pp[2] = p2;
    assign cc[0] = c0;
    assign cc[1] = c1;
    assign cc[2] = c2;

    cdp_pkg::cdp_ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;
    logic [SW-1:0]     sum1_reg, sum2_reg;

    // Control beat travels with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sum1_reg <= sum;
        sum2_reg <= sum1_reg;
    end

    // Stage 1: signed differences, one squarer per component
    logic [SQW-1:0] sq_reg  [3];
    logic [SQW-1:0] sq_next [3];

    always_comb
    begin
        logic signed [DW-1:0]   diff;
        logic signed [2*DW-1:0] prod;
        for (int i = 0; i < 3; i++)
        begin
            diff       = DW'(pp[i]) - DW'(cc[i]);
            prod       = (2*DW)'(diff) * (2*DW)'(diff);
            sq_next[i] = prod[SQW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i] <= sq_next[i];
        end
    end

    // Stage 2: sum of squares back to F fraction bits
    logic [SSW-1:0] sq_sum;
    logic [QW-1:0]  q_reg, q_next;

    assign sq_sum = SSW'(sq_reg[0]) + SSW'(sq_reg[1]) + SSW'(sq_reg[2]) + HALF_Q;
    assign q_next = sq_sum[FRAC_BITS +: QW];

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    // Stage 3: brightness weight
    logic [QSW-1:0] qs_reg, qs_next;

    assign qs_next = QSW'(q_reg) * QSW'(sum2_reg);

    always_ff @(posedge clk)
    begin
        qs_reg <= qs_next;
    end

    // Stage 4: scale, add half the 255 * 2^F divisor, drop the 2^F part
    logic [NW-1:0] num;
    logic [NW:0]   num_rnd;
    logic [TW-1:0] t_reg, t_next;

    assign num     = NW'(qs_reg) * NW'(cdp_pkg::SCALE);
    assign num_rnd = (NW+1)'(num) + DEN_HALF;
    assign t_next  = num_rnd[NW:FRAC_BITS];

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
    end

    // Stage 5: divide by 255 through the reciprocal, saturate, dark override, mask
    logic [31:0]              div_prod;
    logic [cdp_pkg::CH_W-1:0] dist_next;

    always_comb
    begin
        div_prod = 32'(t_reg[cdp_pkg::SAT_W-1:0]) * 32'(cdp_pkg::RECIP255);
        if (ctl4_reg.dark || (t_reg >= TW'(cdp_pkg::SAT_LIMIT)))
        begin
            dist_next = cdp_pkg::DIST_MAX;
        end
        else
        begin
            dist_next = div_prod[cdp_pkg::RECIP_SHIFT +: cdp_pkg::CH_W];
        end
    end

    logic                     done_reg;
    logic [cdp_pkg::CH_W-1:0] distance_reg;
    logic                     mask_reg;
    logic                     dark_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl4_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        distance_reg <= dist_next;
        mask_reg     <= (dist_next > mask_threshold);
        dark_reg     <= ctl4_reg.dark;
    end

    assign done     = done_reg;
    assign distance = distance_reg;
    assign mask     = mask_reg;
    assign dark     = dark_reg;

endmodule

`default_nettype wire

### hw/rtl/chroma_distance_pixel.sv
// Top level of the chroma distance pixel block: config registers, input stage, two lanes.
// Depends on cdp_pkg, cdp_chroma_lane, cdp_recip_div and cdp_dist_back.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  pixel in | start, busy (always 0)  | pix_red, pix_green, pix_blue
//  result   | done (one-cycle strobe) | distance, mask, dark
//  config   | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// One pixel beat per cycle; each result passes the input register, the lane stages (9
// stages of the reciprocal divider at FRAC_BITS = 16, a product and an output register)
// and the back end; the divider, four quotient bits per stage, is most of the depth.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// The receiver cannot stall, so the pipeline never holds; config writes complete at once.
`default_nettype none

module chroma_distance_pixel #(
    parameter int FRAC_BITS = cdp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [cdp_pkg::CH_W-1:0]           pix_red,
    input  wire logic [cdp_pkg::CH_W-1:0]           pix_green,
    input  wire logic [cdp_pkg::CH_W-1:0]           pix_blue,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cdp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [cdp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                    done,
    output logic [cdp_pkg::CH_W-1:0]                distance,
    output logic                                    mask,
    output logic                                    dark
);

    localparam int CW        = cdp_pkg::CH_W;
    localparam int SW        = cdp_pkg::SUM_W;
    localparam int PW        = FRAC_BITS + 2;
    localparam int LANE_LAT  = cdp_pkg::div_stages(FRAC_BITS) + 2;
    localparam int TOTAL_LAT = 1 + LANE_LAT + cdp_pkg::BACK_LAT;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers
    logic [CW-1:0] ref_first_reg, ref_second_reg, ref_third_reg, mask_thr_reg;
    logic [SW-1:0] dark_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_first_reg  <= cdp_pkg::RST_REF_FIRST;
            ref_second_reg <= cdp_pkg::RST_REF_SECOND;
            ref_third_reg  <= cdp_pkg::RST_REF_THIRD;
            dark_limit_reg <= cdp_pkg::RST_DARK_LIMIT;
            mask_thr_reg   <= cdp_pkg::RST_MASK_THR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cdp_pkg::CFG_REF_FIRST:  ref_first_reg  <= cfg_data[CW-1:0];
                cdp_pkg::CFG_REF_SECOND: ref_second_reg <= cfg_data[CW-1:0];
                cdp_pkg::CFG_REF_THIRD:  ref_third_reg  <= cfg_data[CW-1:0];
                cdp_pkg::CFG_DARK_LIMIT: dark_limit_reg <= cfg_data[SW-1:0];
                cdp_pkg::CFG_MASK_THR:   mask_thr_reg   <= cfg_data[CW-1:0];
                default:                 ;
            endcase
        end
    end

    // Input stage: capture the pixel, channel sum and dark flag
    logic [CW-1:0]     red_reg, green_reg, blue_reg;
    logic [SW-1:0]     sum_reg, sum_next;
    cdp_pkg::cdp_ctl_t ctl0_reg, ctl0_next;

    assign sum_next        = SW'(pix_red) + SW'(pix_green) + SW'(pix_blue);
    assign ctl0_next.valid = start && !busy;
    assign ctl0_next.dark  = (sum_next < dark_limit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else
        begin
            ctl0_reg <= ctl0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= pix_red;
        green_reg <= pix_green;
        blue_reg  <= pix_blue;
        sum_reg   <= sum_next;
    end

    // Pixel lane and reference lane; the reference lane runs free on the registers
    logic signed [PW-1:0] p0, p1, p2, c0, c1, c2;

    cdp_chroma_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pix_lane (
        .clk   (clk),
        .a     (red_reg),
        .b     (green_reg),
        .c     (blue_reg),
        .part0 (p0),
        .part1 (p1),
        .part2 (p2)
    );

    cdp_chroma_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ref_lane (
        .clk   (clk),
        .a     (ref_first_reg),
        .b     (ref_second_reg),
        .c     (ref_third_reg),
        .part0 (c0),
        .part1 (c1),
        .part2 (c2)
    );

    // Delay line matching the lane latency
    cdp_pkg::cdp_ctl_t dly_ctl_reg [LANE_LAT];
    logic [SW-1:0]     dly_sum_reg [LANE_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_LAT; i++)
            begin
                dly_ctl_reg[i] <= '0;
            end
        end
        else
        begin
            dly_ctl_reg[0] <= ctl0_reg;
            for (int i = 1; i < LANE_LAT; i++)
            begin
                dly_ctl_reg[i] <= dly_ctl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dly_sum_reg[0] <= sum_reg;
        for (int i = 1; i < LANE_LAT; i++)
        begin
            dly_sum_reg[i] <= dly_sum_reg[i-1];
        end
    end

    cdp_dist_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ctl         (dly_ctl_reg[LANE_LAT-1]),
        .sum            (dly_sum_reg[LANE_LAT-1]),
        .p0             (p0),
        .p1             (p1),
        .p2             (p2),
        .c0             (c0),
        .c1             (c1),
        .c2             (c2),
        .mask_threshold (mask_thr_reg),
        .done           (done),
        .distance       (distance),
        .mask           (mask),
        .dark           (dark)
    );

`ifndef SYNTHESIS
    // Every accepted beat yields its result after the fixed latency
    a_beat_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##TOTAL_LAT done)
        else $error("accepted pixel produced no result");

    // No result without a matching accepted beat
    a_result_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, TOTAL_LAT))
        else $error("result without accepted pixel");

    // Dark pixels report the maximum distance
    a_dark_max: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dark) |-> (distance == cdp_pkg::DIST_MAX))
        else $error("dark pixel distance not saturated");

    // Mask agrees with the delivered distance and the threshold register
    a_mask_match: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (mask == (distance > mask_thr_reg)))
        else $error("mask disagrees with distance");
`endif

endmodule

`default_nettype wire

### test/chroma_distance_pixel_test.sv
// Self-checking testbench for chroma_distance_pixel: drives pixel beats and register writes,
// predicts each distance/mask/dark result and compares it with the block's output.
// Depends on cdp_pkg and the chroma_distance_pixel RTL.
`default_nettype none

module chroma_distance_pixel_test;

    // Widths taken from the package
    localparam int CH_W       = cdp_pkg::CH_W;
    localparam int SUM_W      = cdp_pkg::SUM_W;
    localparam int CFG_IDX_W  = cdp_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = cdp_pkg::CFG_DATA_W;

    // Fixed point constants of the distance computation and stimulus limits
    localparam int              FB    = cdp_pkg::FRAC_BITS_DEF;
    localparam longint unsigned ONE   = 64'd1 << FB;
    localparam longint unsigned HALF  = ONE >> 1;
    localparam longint unsigned THIRD = (2 * ONE + 3) / 6;
    localparam int              MAX_GAP    = 8;
    localparam int              TAIL_WAIT  = 24;
    localparam int              RUN_LIMIT  = 400000;
    localparam int              NUM_PHASES = 8;

    typedef struct packed {
        logic [CH_W-1:0] distance;
        logic            mask;
        logic            dark;
    } pixel_result_t;

    // Scoreboard: register shadow, distance predictor and queue of pending results
    class chroma_scoreboard;
        logic [CH_W-1:0]  ref_a;
        logic [CH_W-1:0]  ref_b;
        logic [CH_W-1:0]  ref_c;
        logic [SUM_W-1:0] dark_limit;
        logic [CH_W-1:0]  mask_thr;
        pixel_result_t    pending_q[$];
        int               errors;

        function new();
            ref_a      = cdp_pkg::RST_REF_FIRST;
            ref_b      = cdp_pkg::RST_REF_SECOND;
            ref_c      = cdp_pkg::RST_REF_THIRD;
            dark_limit = cdp_pkg::RST_DARK_LIMIT;
            mask_thr   = cdp_pkg::RST_MASK_THR;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                cdp_pkg::CFG_REF_FIRST:  ref_a      = data[CH_W-1:0];
                cdp_pkg::CFG_REF_SECOND: ref_b      = data[CH_W-1:0];
                cdp_pkg::CFG_REF_THIRD:  ref_c      = data[CH_W-1:0];
                cdp_pkg::CFG_DARK_LIMIT: dark_limit = data[SUM_W-1:0];
                cdp_pkg::CFG_MASK_THR:   mask_thr   = data[CH_W-1:0];
                default: ;
            endcase
        endfunction

        // Chromaticity of one colour; a zero sum gives one third per part
        function void chroma_parts(longint unsigned a, longint unsigned b, longint unsigned c,
                                   output longint pa, output longint pb, output longint pc);
            longint unsigned sum;
            longint unsigned recip;
            sum = a + b + c;
            if (sum == 0)
            begin
                pa = longint'(THIRD);
                pb = longint'(THIRD);
                pc = longint'(THIRD);
            end
            else
            begin
                recip = (64'd1 << (2 * FB)) / sum;
                pa = longint'((a * recip + HALF) >> FB);
                pb = longint'((b * recip + HALF) >> FB);
                pc = longint'(ONE) - pa - pb;
            end
        endfunction

        function pixel_result_t chroma_distance(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                                logic [CH_W-1:0] b);
            pixel_result_t   res;
            longint unsigned sum;
            longint unsigned sq;
            longint unsigned q;
            longint unsigned den;
            longint unsigned dist_val;
            longint          p0, p1, p2, c0, c1, c2, d0, d1, d2;
            sum = longint'(r) + longint'(g) + longint'(b);
            res.dark = 1'b0;
            if (sum < longint'(dark_limit))
            begin
                dist_val = 255;
                res.dark = 1'b1;
            end
            else
            begin
                chroma_parts(longint'(r), longint'(g), longint'(b), p0, p1, p2);
                chroma_parts(longint'(ref_a), longint'(ref_b), longint'(ref_c), c0, c1, c2);
                d0 = p0 - c0;
                d1 = p1 - c1;
                d2 = p2 - c2;
                sq = longint'(d0 * d0) + longint'(d1 * d1) + longint'(d2 * d2);
                q = (sq + HALF) >> FB;
                den = 64'd255 << FB;
                dist_val = (q * sum * cdp_pkg::SCALE + den / 2) / den;
                if (dist_val > 255)
                    dist_val = 255;
            end
            res.distance = dist_val[CH_W-1:0];
            res.mask     = (dist_val > longint'(mask_thr));
            return res;
        endfunction

        function void note_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
            pending_q.push_back(chroma_distance(r, g, b));
        endfunction

        function void check_result(logic [CH_W-1:0] dist_in, logic msk, logic drk);
            pixel_result_t exp_res;
            if (pending_q.size() == 0)
            begin
                $error("result with no pending pixel: distance %0d, mask %0d, dark %0d",
                       dist_in, msk, drk);
                errors++;
            end
            else
            begin
                exp_res = pending_q.pop_front();
                if (dist_in !== exp_res.distance)
                begin
                    $error("distance mismatch: expected %0d, actual %0d",
                           exp_res.distance, dist_in);
                    errors++;
                end
                if (msk !== exp_res.mask)
                begin
                    $error("mask mismatch: expected %0d, actual %0d", exp_res.mask, msk);
                    errors++;
                end
                if (drk !== exp_res.dark)
                begin
                    $error("dark mismatch: expected %0d, actual %0d", exp_res.dark, drk);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    // Clock, reset and block inputs
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic [CH_W-1:0]       pix_red   = '0;
    logic [CH_W-1:0]       pix_green = '0;
    logic [CH_W-1:0]       pix_blue  = '0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  busy;
    logic                  cfg_ready;
    logic                  done;
    logic [CH_W-1:0]       distance;
    logic                  mask;
    logic                  dark;

    chroma_scoreboard sb = new();

    chroma_distance_pixel u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pix_red   (pix_red),
        .pix_green (pix_green),
        .pix_blue  (pix_blue),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .distance  (distance),
        .mask      (mask),
        .dark      (dark)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result monitor: values seen at the edge are those of the cycle it ends
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(distance, mask, dark);
    end

    // One pixel beat; start stays high across back-to-back beats
    task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        pix_red   <= r;
        pix_green <= g;
        pix_blue  <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_pixel(r, g, b);
    endtask

    // Stop sending and wait until every pending result has come back
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // One register write beat; the caller lowers cfg_valid after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] ra, input logic [CFG_DATA_W-1:0] rb,
                             input logic [CFG_DATA_W-1:0] rc, input logic [CFG_DATA_W-1:0] lim,
                             input logic [CFG_DATA_W-1:0] thr);
        write_reg(cdp_pkg::CFG_REF_FIRST, ra);
        write_reg(cdp_pkg::CFG_REF_SECOND, rb);
        write_reg(cdp_pkg::CFG_REF_THIRD, rc);
        write_reg(cdp_pkg::CFG_DARK_LIMIT, lim);
        write_reg(cdp_pkg::CFG_MASK_THR, thr);
        cfg_valid <= 1'b0;
    endtask

    // Byte with extra weight on both ends of the range
    function automatic logic [CH_W-1:0] rand_byte();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Stimulus
    initial
    begin
        int                    phase;
        int                    k;
        int                    n_items;
        int                    gap;
        int                    target;
        int                    lo;
        int                    hi;
        int                    rem;
        bit                    burst;
        logic [CH_W-1:0]       r, g, b;
        logic [CFG_DATA_W-1:0] lim;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: pure red reference, no dark limit
        send_pixel(8'd0, 8'd0, 8'd0, 0);
        send_pixel(8'd255, 8'd0, 8'd0, 0);
        send_pixel(8'd0, 8'd255, 8'd0, 1);
        send_pixel(8'd0, 8'd0, 8'd255, 0);
        send_pixel(8'd255, 8'd255, 8'd255, 2);
        send_pixel(8'd1, 8'd0, 8'd0, 0);
        send_pixel(8'd128, 8'd64, 8'd32, 0);
        drain();

        // Unused indexes are ignored; then black reference, small dark limit, zero threshold
        for (k = int'(cdp_pkg::CFG_MASK_THR) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom_range(0, 1023)));
        configure(10'd0, 10'd0, 10'd0, 10'd3, 10'd0);
        send_pixel(8'd0, 8'd0, 8'd0, 1);
        send_pixel(8'd1, 8'd1, 8'd0, 0);
        send_pixel(8'd1, 8'd1, 8'd1, 0);
        send_pixel(8'd255, 8'd255, 8'd255, 0);
        send_pixel(8'd0, 8'd0, 8'd3, 3);
        drain();

        // Limit beyond the largest sum: everything dark; top threshold clears mask
        configure(10'h3FF, 10'h2FF, 10'd255, 10'd1023, 10'd255);
        send_pixel(8'd255, 8'd255, 8'd255, 0);
        send_pixel(8'd0, 8'd0, 8'd0, 0);
        drain();

        configure(10'd0, 10'd0, 10'd255, 10'd766, 10'd254);
        send_pixel(8'd255, 8'd255, 8'd255, 0);
        send_pixel(8'd255, 8'd255, 8'd0, 1);
        drain();

        // Limit right at the largest sum
        configure(10'd200, 10'd100, 10'd50, 10'd765, 10'd128);
        send_pixel(8'd255, 8'd255, 8'd255, 0);
        send_pixel(8'd254, 8'd255, 8'd255, 0);
        drain();

        configure(10'd0, 10'd255, 10'd0, 10'd0, 10'd0);
        send_pixel(8'd0, 8'd0, 8'd0, 0);
        send_pixel(8'd0, 8'd255, 8'd0, 0);
        send_pixel(8'd255, 8'd0, 8'd255, 0);
        drain();

        // Random phases, each with its own register setting
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       lim = '0;
                1:       lim = CFG_DATA_W'($urandom_range(766, 1023));
                2:       lim = CFG_DATA_W'($urandom_range(0, 60));
                default: lim = CFG_DATA_W'($urandom_range(0, 765));
            endcase
            if ($urandom_range(0, 7) == 0)
                configure({2'($urandom_range(0, 3)), 8'd0}, {2'($urandom_range(0, 3)), 8'd0},
                          {2'($urandom_range(0, 3)), 8'd0}, lim,
                          {2'($urandom_range(0, 3)), rand_byte()});
            else
                configure({2'($urandom_range(0, 3)), rand_byte()},
                          {2'($urandom_range(0, 3)), rand_byte()},
                          {2'($urandom_range(0, 3)), rand_byte()}, lim,
                          {2'($urandom_range(0, 3)), rand_byte()});
            burst   = ($urandom_range(0, 3) == 0);
            n_items = $urandom_range(90, 120);
            for (k = 0; k < n_items; k++)
            begin
                case ($urandom_range(0, 7))
                    // Sum within a couple of counts of the dark limit
                    0:
                    begin
                        target = int'(sb.dark_limit) + int'($urandom_range(0, 3)) - 2;
                        if (target < 0)
                            target = 0;
                        if (target > 765)
                            target = 765;
                        lo = (target > 510) ? target - 510 : 0;
                        hi = (target < 255) ? target : 255;
                        r = CH_W'($urandom_range(lo, hi));
                        rem = target - int'(r);
                        lo = (rem > 255) ? rem - 255 : 0;
                        hi = (rem < 255) ? rem : 255;
                        g = CH_W'($urandom_range(lo, hi));
                        b = CH_W'(rem - int'(g));
                    end
                    1, 2:
                    begin
                        r = rand_byte();
                        g = rand_byte();
                        b = rand_byte();
                    end
                    default:
                    begin
                        r = CH_W'($urandom_range(0, 255));
                        g = CH_W'($urandom_range(0, 255));
                        b = CH_W'($urandom_range(0, 255));
                    end
                endcase
                gap = burst ? 0 : $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 63) == 0)
                    drain();
                send_pixel(r, g, b, gap);
            end
            drain();
        end

        repeat (TAIL_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #RUN_LIMIT;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
